// ----- hw/rtl/bpa_pkg.sv -----
`default_nettype none
package bpa_pkg;

  // Fixed field and datapath widths.
  localparam int START_W = 18;  // page numbers with room for a block end past the pool
  localparam int ORD_W   = 5;   // order values up to thirty-one
  localparam int WORD_W  = 64;  // bits per memory word of the free map
  localparam int BIT_W   = 6;

  // Datapath operations.
  localparam logic [3:0] OP_NOP  = 4'd0;
  localparam logic [3:0] OP_LOAD = 4'd1;
  localparam logic [3:0] OP_FIND = 4'd2;
  localparam logic [3:0] OP_FRD  = 4'd3;
  localparam logic [3:0] OP_PICK = 4'd4;
  localparam logic [3:0] OP_SRD  = 4'd5;
  localparam logic [3:0] OP_SWR  = 4'd6;
  localparam logic [3:0] OP_MRD  = 4'd7;
  localparam logic [3:0] OP_MCLR = 4'd8;
  localparam logic [3:0] OP_TRD  = 4'd9;
  localparam logic [3:0] OP_INIT = 4'd10;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [10:0] page_count;
    logic [11:0] page_index;
  } bpa_req_t;

  typedef struct packed {
    logic [11:0] start_page;
    logic        status;
  } bpa_resp_t;

  typedef struct packed {
    logic [3:0] op;
    logic       emit;
    logic       fail;
  } dp_cmd_t;

  typedef struct packed {
    logic init_done;
    logic alloc;
    logic too_big;
    logic hit;
    logic more_split;
    logic fits;
    logic can_merge;
    logic buddy_free;
  } dp_stat_t;

  // Order of a page count: ceil(log2(count)), zero for counts of zero and one.
  function automatic logic [ORD_W-1:0] count_to_order(input logic [10:0] cnt);
    logic [10:0]      c;
    logic [ORD_W-1:0] k;
    c = cnt - 11'd1;
    k = '0;
    if (cnt > 11'd1) begin
      for (int i = 0; i < 11; i++) begin
        if (c[i]) k = ORD_W'(i + 1);
      end
    end
    return k;
  endfunction

  // Lowest set bit of a map word.
  function automatic logic [BIT_W-1:0] low_bit(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] b;
    b = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) b = BIT_W'(i);
    end
    return b;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/bpa_ctrl.sv -----
`default_nettype none
module bpa_ctrl
  import bpa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire dp_stat_t stat,
  output dp_cmd_t       dcmd
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_FOUND  = 4'd3;
  localparam logic [3:0] S_PICK   = 4'd4;
  localparam logic [3:0] S_SCHK   = 4'd5;
  localparam logic [3:0] S_SWR    = 4'd6;
  localparam logic [3:0] S_MCHK   = 4'd7;
  localparam logic [3:0] S_MTEST  = 4'd8;
  localparam logic [3:0] S_TWR    = 4'd9;

  logic [3:0] state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  // Next state and datapath command.
  always_comb begin
    state_nxt = state_r;
    dcmd      = '{op: OP_NOP, emit: 1'b0, fail: 1'b0};
    unique case (state_r)
      S_INIT: begin
        if (stat.init_done) state_nxt = S_IDLE;
        else dcmd.op = OP_INIT;
      end
      S_IDLE: begin
        if (start) begin
          dcmd.op   = OP_LOAD;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.too_big) begin
          dcmd.emit = 1'b1;
          dcmd.fail = stat.alloc;
          state_nxt = S_IDLE;
        end else if (stat.alloc) begin
          dcmd.op   = OP_FIND;
          state_nxt = S_FOUND;
        end else if (!stat.fits) begin
          dcmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_MCHK;
        end
      end
      S_FOUND: begin
        if (!stat.hit) begin
          dcmd.emit = 1'b1;
          dcmd.fail = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          dcmd.op   = OP_FRD;
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        dcmd.op   = OP_PICK;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (stat.more_split) begin
          dcmd.op   = OP_SRD;
          state_nxt = S_SWR;
        end else begin
          dcmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SWR: begin
        dcmd.op   = OP_SWR;
        state_nxt = S_SCHK;
      end
      S_MCHK: begin
        if (stat.can_merge) begin
          dcmd.op   = OP_MRD;
          state_nxt = S_MTEST;
        end else begin
          dcmd.op   = OP_TRD;
          state_nxt = S_TWR;
        end
      end
      S_MTEST: begin
        if (stat.buddy_free) begin
          dcmd.op   = OP_MCLR;
          state_nxt = S_MCHK;
        end else begin
          dcmd.op   = OP_TRD;
          state_nxt = S_TWR;
        end
      end
      S_TWR: begin
        dcmd.op   = OP_SWR;
        dcmd.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else state_r <= state_nxt;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/bpa_datapath.sv -----
`default_nettype none
module bpa_datapath
  import bpa_pkg::*;
#(
  parameter int TOP_ORDER  = 10,
  parameter int POOL_PAGES = 4096
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire bpa_req_t in_req,
  input  wire dp_cmd_t  dcmd,
  output dp_stat_t      stat,
  output logic          out_valid,
  output bpa_resp_t     out_resp
);

  localparam int OA_W   = $clog2(TOP_ORDER + 1);
  localparam int NWORDS = (POOL_PAGES + WORD_W - 1) / WORD_W;
  localparam int WIDX_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int SUMW   = 1 << WIDX_W;
  localparam int AW     = OA_W + WIDX_W;
  localparam int DEPTH  = 1 << AW;
  localparam logic [START_W:0] POOL_X = (START_W + 1)'(POOL_PAGES);
  localparam logic [ORD_W-1:0] TOP_O  = ORD_W'(TOP_ORDER);

  // Free map words, one row of words per order.
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;
  // One bit per word that tells whether the word holds any free block.
  logic [SUMW-1:0]   summ_r [TOP_ORDER + 1];

  logic                 cmd_r;
  logic [ORD_W-1:0]     req_order_r, ord_r;
  logic [START_W-1:0]   start_r;
  logic [AW-1:0]        addr_r;
  logic [BIT_W-1:0]     bit_r;
  logic                 hit_r;
  logic [AW:0]          init_cnt_r;
  logic                 out_valid_r;
  bpa_resp_t            out_resp_r;

  logic [ORD_W-1:0]     sel_ord, load_ord, found_ord;
  logic [START_W-1:0]   sel_pos, buddy;
  logic [AW-1:0]        raddr, waddr;
  logic [WORD_W-1:0]    wdata, init_word;
  logic                 we, found_hit;
  logic [WIDX_W-1:0]    first_word;
  logic [BIT_W-1:0]     pick_bit;
  logic [START_W-1:0]   pos_b;

  assign load_ord = count_to_order(in_req.page_count);
  assign pick_bit = low_bit(rd_data_r);
  assign buddy    = start_r ^ (START_W'(1) << ord_r);

  // Lowest order at or above the request that holds a free block.
  always_comb begin
    found_ord = '0;
    found_hit = 1'b0;
    for (int k = 0; k <= TOP_ORDER; k++) begin
      if (!found_hit && ORD_W'(k) >= req_order_r && (|summ_r[k])) begin
        found_ord = ORD_W'(k);
        found_hit = 1'b1;
      end
    end
  end

  // First non-empty word of the chosen order.
  always_comb begin
    first_word = '0;
    for (int i = SUMW - 1; i >= 0; i--) begin
      if (summ_r[ord_r[OA_W-1:0]][i]) first_word = WIDX_W'(i);
    end
  end

  // Reset image of the word swept by the clearing pass.
  always_comb begin
    init_word = '0;
    for (int b = 0; b < WORD_W; b++) begin
      pos_b = START_W'({init_cnt_r[WIDX_W-1:0], BIT_W'(b)});
      if (ORD_W'(init_cnt_r[AW-1:WIDX_W]) == TOP_O) begin
        init_word[b] = (START_W + 1)'(pos_b) < (POOL_X >> TOP_ORDER);
      end else if (ORD_W'(init_cnt_r[AW-1:WIDX_W]) < TOP_O) begin
        init_word[b] = POOL_X[init_cnt_r[AW-1:WIDX_W]] &&
          ((START_W + 1)'(pos_b) ==
           ((POOL_X >> init_cnt_r[AW-1:WIDX_W]) & ~(START_W + 1)'(1)));
      end
    end
  end

  // Block position and word address for each read.
  always_comb begin
    sel_ord = ord_r;
    sel_pos = start_r >> ord_r;
    unique case (dcmd.op)
      OP_FRD: sel_pos = START_W'({first_word, BIT_W'(0)});
      OP_SRD: begin
        sel_ord = ord_r - ORD_W'(1);
        sel_pos = (start_r + (START_W'(1) << sel_ord)) >> sel_ord;
      end
      OP_MRD:  sel_pos = buddy >> ord_r;
      default: sel_pos = start_r >> ord_r;
    endcase
    raddr = {sel_ord[OA_W-1:0], sel_pos[WIDX_W+BIT_W-1:BIT_W]};
  end

  // Map word writes.
  always_comb begin
    we    = 1'b0;
    waddr = addr_r;
    wdata = rd_data_r;
    unique case (dcmd.op)
      OP_INIT: begin
        we    = 1'b1;
        waddr = init_cnt_r[AW-1:0];
        wdata = init_word;
      end
      OP_PICK: begin
        we    = 1'b1;
        wdata = rd_data_r & ~(WORD_W'(1) << pick_bit);
      end
      OP_SWR: begin
        we    = 1'b1;
        wdata = rd_data_r | (WORD_W'(1) << bit_r);
      end
      OP_MCLR: begin
        we    = 1'b1;
        wdata = rd_data_r & ~(WORD_W'(1) << bit_r);
      end
      default: we = 1'b0;
    endcase
  end

  // Memory.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_data_r <= mem[raddr];
  end

  // Word summary follows every map write to the row of an order up to TOP_ORDER.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= TOP_ORDER; k++) summ_r[k] <= '0;
    end else if (we && (ORD_W'(waddr[AW-1:WIDX_W]) <= TOP_O)) begin
      summ_r[waddr[AW-1:WIDX_W]][waddr[WIDX_W-1:0]] <= |wdata;
    end
  end

  // Clearing pass counter.
  always_ff @(posedge clk) begin
    if (!rst_n) init_cnt_r <= '0;
    else if (dcmd.op == OP_INIT) init_cnt_r <= init_cnt_r + (AW + 1)'(1);
  end

  // Request registers.
  always_ff @(posedge clk) begin
    unique case (dcmd.op) inside
      OP_LOAD: begin
        cmd_r       <= in_req.cmd;
        req_order_r <= load_ord;
        ord_r       <= load_ord;
        start_r     <= START_W'(in_req.page_index) & ~((START_W'(1) << load_ord) - START_W'(1));
      end
      OP_FIND: begin
        ord_r <= found_ord;
        hit_r <= found_hit;
      end
      OP_FRD: begin
        addr_r  <= raddr;
        start_r <= sel_pos << ord_r;
      end
      OP_PICK: start_r <= start_r | (START_W'(pick_bit) << ord_r);
      OP_SRD, OP_MRD, OP_TRD: begin
        addr_r <= raddr;
        bit_r  <= sel_pos[BIT_W-1:0];
        if (dcmd.op == OP_SRD) ord_r <= sel_ord;
      end
      OP_MCLR: begin
        start_r <= start_r & ~(START_W'(1) << ord_r);
        ord_r   <= ord_r + ORD_W'(1);
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= dcmd.emit;
    if (dcmd.emit) begin
      out_resp_r.start_page <= (dcmd.fail || cmd_r != CMD_ALLOC) ? 12'd0 : start_r[11:0];
      out_resp_r.status     <= dcmd.fail;
    end
  end

  assign out_valid = out_valid_r;
  assign out_resp  = out_resp_r;

  // Status to the controller.
  always_comb begin
    stat.init_done  = init_cnt_r[AW];
    stat.alloc      = (cmd_r == CMD_ALLOC);
    stat.too_big    = req_order_r > TOP_O;
    stat.hit        = hit_r;
    stat.more_split = ord_r > req_order_r;
    stat.fits       = ((START_W + 1)'(start_r) + ((START_W + 1)'(1) << ord_r)) <= POOL_X;
    stat.can_merge  = (ord_r < TOP_O) &&
                      (((START_W + 1)'(buddy) + ((START_W + 1)'(1) << ord_r)) <= POOL_X);
    stat.buddy_free = rd_data_r[bit_r];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/buddy_page_allocator_core.sv -----
// An allocate finds and picks a free block and then splits it down to the requested order;
// a release merges the block with its free buddies until no merge is possible, then frees it.
// Each split or merge step is a read and a write of the free map memory.
// One request at a time; busy drops in the cycle the result is strobed on out_valid.
// After reset a clearing pass writes 2^(ceil(log2(TOP_ORDER + 1)) + ceil(log2(POOL_PAGES / 64)))
// map words, 1024 at the default sizes, with busy held high; results cannot stall.
`default_nettype none
module buddy_page_allocator_core
  import bpa_pkg::*;
#(
  parameter int TOP_ORDER  = 10,
  parameter int POOL_PAGES = 4096
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire bpa_req_t in_req,
  output logic          out_valid,
  output bpa_resp_t     out_resp
);

  dp_cmd_t  dcmd;
  dp_stat_t stat;

  bpa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .dcmd  (dcmd)
  );

  bpa_datapath #(
    .TOP_ORDER  (TOP_ORDER),
    .POOL_PAGES (POOL_PAGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .dcmd      (dcmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_resp  (out_resp)
  );

endmodule
`default_nettype wire
